[sv/a64x_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and decode helpers for the integer subset execute block.
package a64x_pkg;

   localparam int XLEN      = 64;
   localparam int NUM_REGS  = 32;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int FLAGS_W   = 4;

   localparam logic [REG_IDX_W-1:0] ZERO_REG = REG_IDX_W'(NUM_REGS - 1);

   typedef enum logic [1:0] {
      OP_EXEC  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_IDLE  = 2'd3
   } op_type;

   localparam logic [31:0] NOP_WORD  = 32'hD503_201F;
   localparam logic [31:0] RET_MASK  = 32'hFFFF_FC1F;
   localparam logic [31:0] RET_MATCH = 32'hD65F_0000;

   localparam logic [5:0] CLASS_MOVW = 6'h25;
   localparam logic [5:0] CLASS_ADDI = 6'h22;
   localparam logic [4:0] CLASS_ADDR = 5'h0B;

   localparam logic [1:0] MOV_N    = 2'd0;
   localparam logic [1:0] MOV_RSVD = 2'd1;
   localparam logic [1:0] MOV_Z    = 2'd2;
   localparam logic [1:0] MOV_K    = 2'd3;

   localparam logic [1:0] SH_LSL  = 2'd0;
   localparam logic [1:0] SH_LSR  = 2'd1;
   localparam logic [1:0] SH_ASR  = 2'd2;
   localparam logic [1:0] SH_RSVD = 2'd3;

   localparam logic [2:0] EXT_UXTB = 3'd0;
   localparam logic [2:0] EXT_UXTH = 3'd1;
   localparam logic [2:0] EXT_UXTW = 3'd2;
   localparam logic [2:0] EXT_SXTB = 3'd4;
   localparam logic [2:0] EXT_SXTH = 3'd5;
   localparam logic [2:0] EXT_SXTW = 3'd6;

   localparam logic [2:0] EXT_MAX_SHIFT = 3'd4;

   typedef struct packed {
      logic [XLEN-1:0]      next_pc;
      logic                 wr_en;
      logic [REG_IDX_W-1:0] wr_idx;
      logic [XLEN-1:0]      wr_val;
      logic                 flag_wr;
      logic [FLAGS_W-1:0]   flags;
      logic                 unimp;
   } exec_res_type;

   function automatic logic is_movw(input logic [31:0] word);
      return word[28:23] == CLASS_MOVW;
   endfunction

endpackage

[sv/a64x_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read-first output.
module a64x_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/a64x_exec.sv]
`timescale 1ns / 1ps
// Instruction decode, operand shaping, adder and flag generation for one execute transaction.
module a64x_exec (
   input  logic [31:0]                  instr_word,
   input  logic [a64x_pkg::XLEN-1:0]    instr_addr,
   input  logic [a64x_pkg::XLEN-1:0]    opa_value,
   input  logic [a64x_pkg::XLEN-1:0]    opb_value,
   output a64x_pkg::exec_res_type       result
);

   always_comb begin
      logic                             sf;
      logic                             setf;
      logic [a64x_pkg::REG_IDX_W-1:0]   rd;
      logic [a64x_pkg::REG_IDX_W-1:0]   rn;
      logic [a64x_pkg::REG_IDX_W-1:0]   rm;
      logic [a64x_pkg::XLEN-1:0]        pc4;
      logic [a64x_pkg::XLEN-1:0]        a_zr;
      logic [a64x_pkg::XLEN-1:0]        b_zr;
      logic [1:0]                       mopc;
      logic [1:0]                       hw;
      logic [5:0]                       hw_sh;
      logic [a64x_pkg::XLEN-1:0]        imm_w;
      logic [a64x_pkg::XLEN-1:0]        keep;
      logic [a64x_pkg::XLEN-1:0]        mv;
      logic [1:0]                       sh_type;
      logic [5:0]                       sh_amt;
      logic [a64x_pkg::XLEN-1:0]        b_m;
      logic [a64x_pkg::XLEN-1:0]        b_sx;
      logic [a64x_pkg::XLEN-1:0]        shifted;
      logic [a64x_pkg::XLEN-1:0]        ext;
      logic                             use_alu;
      logic                             alu_sub;
      logic                             alu_sp_rd;
      logic [a64x_pkg::XLEN-1:0]        alu_x;
      logic [a64x_pkg::XLEN-1:0]        alu_y;
      logic [a64x_pkg::XLEN-1:0]        x_m;
      logic [a64x_pkg::XLEN-1:0]        y_m;
      logic [a64x_pkg::XLEN:0]          sum;
      logic [a64x_pkg::XLEN-1:0]        r;
      logic [a64x_pkg::XLEN-1:0]        ovf;
      logic                             fn;
      logic                             fz;
      logic                             fc;
      logic                             fv;

      sf      = instr_word[31];
      setf    = instr_word[29];
      rd      = instr_word[4:0];
      rn      = instr_word[9:5];
      rm      = instr_word[20:16];
      pc4     = instr_addr + a64x_pkg::XLEN'(4);
      a_zr    = (rn == a64x_pkg::ZERO_REG) ? '0 : opa_value;
      b_zr    = (rm == a64x_pkg::ZERO_REG) ? '0 : opb_value;
      mopc    = instr_word[30:29];
      hw      = instr_word[22:21];
      hw_sh   = {hw, 4'b0000};
      imm_w   = {48'b0, instr_word[20:5]} << hw_sh;
      keep    = ~({48'b0, 16'hFFFF} << hw_sh);
      mv      = '0;
      sh_type = instr_word[23:22];
      sh_amt  = instr_word[15:10];
      b_m     = sf ? b_zr : {32'b0, b_zr[31:0]};
      b_sx    = sf ? b_zr : {{32{b_zr[31]}}, b_zr[31:0]};
      shifted = '0;
      ext     = b_zr;
      use_alu = 1'b0;
      alu_sub = 1'b0;
      alu_sp_rd = 1'b0;
      alu_x   = '0;
      alu_y   = '0;

      result         = '0;
      result.next_pc = pc4;

      if (instr_word == a64x_pkg::NOP_WORD) begin
         result.unimp = 1'b0;
      end else if ((instr_word & a64x_pkg::RET_MASK) == a64x_pkg::RET_MATCH) begin
         result.next_pc = a_zr;
      end else if (a64x_pkg::is_movw(instr_word)) begin
         if (mopc == a64x_pkg::MOV_RSVD || (!sf && hw[1])) begin
            result.unimp = 1'b1;
         end else begin
            case (mopc)
               a64x_pkg::MOV_N: mv = ~imm_w;
               a64x_pkg::MOV_Z: mv = imm_w;
               a64x_pkg::MOV_K: begin
                  mv = ((rd == a64x_pkg::ZERO_REG) ? '0 : opa_value) & keep | imm_w;
               end
               default: mv = '0;
            endcase
            if (!sf) begin
               mv = {32'b0, mv[31:0]};
            end
            result.wr_en  = (rd != a64x_pkg::ZERO_REG);
            result.wr_idx = rd;
            result.wr_val = mv;
         end
      end else if (instr_word[28:23] == a64x_pkg::CLASS_ADDI) begin
         use_alu   = 1'b1;
         alu_sub   = instr_word[30];
         alu_sp_rd = !setf;
         alu_x     = opa_value;
         alu_y     = instr_word[22] ? {40'b0, instr_word[21:10], 12'b0}
                                    : {52'b0, instr_word[21:10]};
      end else if (instr_word[28:24] == a64x_pkg::CLASS_ADDR && !instr_word[30]) begin
         if (!instr_word[21]) begin
            if (sh_type == a64x_pkg::SH_RSVD || (!sf && sh_amt[5])) begin
               result.unimp = 1'b1;
            end else begin
               case (sh_type)
                  a64x_pkg::SH_LSL: shifted = b_m << sh_amt;
                  a64x_pkg::SH_LSR: shifted = b_m >> sh_amt;
                  a64x_pkg::SH_ASR: shifted = a64x_pkg::XLEN'($signed(b_sx) >>> sh_amt);
                  default:          shifted = '0;
               endcase
               use_alu   = 1'b1;
               alu_sp_rd = 1'b0;
               alu_x     = a_zr;
               alu_y     = shifted;
            end
         end else begin
            if (instr_word[23:22] != 2'b00 || instr_word[12:10] > a64x_pkg::EXT_MAX_SHIFT) begin
               result.unimp = 1'b1;
            end else begin
               case (instr_word[15:13])
                  a64x_pkg::EXT_UXTB: ext = {56'b0, b_zr[7:0]};
                  a64x_pkg::EXT_UXTH: ext = {48'b0, b_zr[15:0]};
                  a64x_pkg::EXT_UXTW: ext = {32'b0, b_zr[31:0]};
                  a64x_pkg::EXT_SXTB: ext = {{56{b_zr[7]}}, b_zr[7:0]};
                  a64x_pkg::EXT_SXTH: ext = {{48{b_zr[15]}}, b_zr[15:0]};
                  a64x_pkg::EXT_SXTW: ext = {{32{b_zr[31]}}, b_zr[31:0]};
                  default:            ext = b_zr;
               endcase
               use_alu   = 1'b1;
               alu_sp_rd = !setf;
               alu_x     = opa_value;
               alu_y     = ext << instr_word[12:10];
            end
         end
      end else begin
         result.unimp = 1'b1;
      end

      x_m = sf ? alu_x : {32'b0, alu_x[31:0]};
      y_m = alu_sub ? ~alu_y : alu_y;
      y_m = sf ? y_m : {32'b0, y_m[31:0]};
      sum = {1'b0, x_m} + {1'b0, y_m} + {64'b0, alu_sub};
      r   = sf ? sum[a64x_pkg::XLEN-1:0] : {32'b0, sum[31:0]};
      ovf = ~(x_m ^ y_m) & (x_m ^ r);
      fn  = sf ? r[63] : r[31];
      fz  = (r == '0);
      fc  = sf ? sum[64] : sum[32];
      fv  = sf ? ovf[63] : ovf[31];

      if (use_alu) begin
         result.wr_en   = alu_sp_rd || (rd != a64x_pkg::ZERO_REG);
         result.wr_idx  = rd;
         result.wr_val  = r;
         result.flag_wr = setf;
         result.flags   = {fn, fz, fc, fv};
      end
      if (!result.wr_en) begin
         result.wr_idx = '0;
         result.wr_val = '0;
      end
   end

endmodule

[sv/arm64_integer_subset_execute.sv]
`timescale 1ns / 1ps
// Top level of the integer subset execute block: register file RAM, bypass and output register.
// Takes one transaction per cycle while the input is not stalled. An accepted request is registered
// into the execute stage and its result then into the output register, where the result handshake
// is offered. At acceptance the source registers are read from the 32 x 64 register file (two
// RAM copies, one per read port); the execute stage executes and writes back as its result moves
// on, with a one-entry bypass covering the write that lands on the same edge as a later read.
// Register 31 is the stack pointer for direct writes and reads. While a result waits in the
// output register one more transaction is taken into the execute stage; the input then stalls
// until the result leaves. The file and flags are zero after reset; no clearing pass is needed.
module arm64_integer_subset_execute (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic [31:0]                         req_instr_word,
   input  logic [a64x_pkg::XLEN-1:0]           req_instr_addr,
   input  logic [a64x_pkg::REG_IDX_W-1:0]      req_reg_index,
   input  logic [a64x_pkg::XLEN-1:0]           req_reg_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [a64x_pkg::XLEN-1:0]           rsp_next_pc,
   output logic                                rsp_dest_written,
   output logic [a64x_pkg::REG_IDX_W-1:0]      rsp_dest_index,
   output logic [a64x_pkg::XLEN-1:0]           rsp_dest_value,
   output logic [a64x_pkg::FLAGS_W-1:0]        rsp_flags_nzcv,
   output logic [a64x_pkg::XLEN-1:0]           rsp_read_value,
   output logic                                rsp_unimplemented
);

   logic                                req_accept;
   logic                                s1_move;
   a64x_pkg::op_type                    req_op;
   logic [a64x_pkg::REG_IDX_W-1:0]      rd_addr_a;
   logic [a64x_pkg::REG_IDX_W-1:0]      rd_addr_b;
   logic [a64x_pkg::XLEN-1:0]           ram_a_data;
   logic [a64x_pkg::XLEN-1:0]           ram_b_data;

   logic                                s1_valid_ff;
   logic                                s1_valid_in;
   a64x_pkg::op_type                    s1_op_ff;
   logic [31:0]                         s1_word_ff;
   logic [a64x_pkg::XLEN-1:0]           s1_addr_ff;
   logic [a64x_pkg::REG_IDX_W-1:0]      s1_idx_ff;
   logic [a64x_pkg::XLEN-1:0]           s1_value_ff;
   logic [a64x_pkg::REG_IDX_W-1:0]      opa_idx_ff;
   logic [a64x_pkg::REG_IDX_W-1:0]      opb_idx_ff;

   logic                                fwd_valid_ff;
   logic [a64x_pkg::REG_IDX_W-1:0]      fwd_idx_ff;
   logic [a64x_pkg::XLEN-1:0]           fwd_val_ff;
   logic [a64x_pkg::NUM_REGS-1:0]       valid_ff;
   logic [a64x_pkg::FLAGS_W-1:0]        nzcv_ff;

   logic [a64x_pkg::XLEN-1:0]           opa;
   logic [a64x_pkg::XLEN-1:0]           opb;
   a64x_pkg::exec_res_type              ex_res;

   logic                                c_wr_en;
   logic [a64x_pkg::REG_IDX_W-1:0]      c_wr_idx;
   logic [a64x_pkg::XLEN-1:0]           c_wr_val;
   logic [a64x_pkg::XLEN-1:0]           c_next_pc;
   logic [a64x_pkg::FLAGS_W-1:0]        c_flags;
   logic                                c_flag_wr;
   logic [a64x_pkg::XLEN-1:0]           c_read_val;
   logic                                c_unimp;
   logic                                commit_wr;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [a64x_pkg::XLEN-1:0]           rsp_next_pc_ff;
   logic                                rsp_dest_written_ff;
   logic [a64x_pkg::REG_IDX_W-1:0]      rsp_dest_index_ff;
   logic [a64x_pkg::XLEN-1:0]           rsp_dest_value_ff;
   logic [a64x_pkg::FLAGS_W-1:0]        rsp_flags_ff;
   logic [a64x_pkg::XLEN-1:0]           rsp_read_value_ff;
   logic                                rsp_unimp_ff;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;
   assign req_op     = a64x_pkg::op_type'(req_opcode);

   always_comb begin
      if (req_op == a64x_pkg::OP_WRITE || req_op == a64x_pkg::OP_READ) begin
         rd_addr_a = req_reg_index;
      end else if (a64x_pkg::is_movw(req_instr_word)) begin
         rd_addr_a = req_instr_word[4:0];
      end else begin
         rd_addr_a = req_instr_word[9:5];
      end
      rd_addr_b = req_instr_word[20:16];
   end

   a64x_ram #(.WIDTH(a64x_pkg::XLEN), .DEPTH(a64x_pkg::NUM_REGS)) u_ram_a (
      .clock   (clock),
      .wr_en   (commit_wr),
      .wr_addr (c_wr_idx),
      .wr_data (c_wr_val),
      .rd_en   (req_accept),
      .rd_addr (rd_addr_a),
      .rd_data (ram_a_data)
   );

   a64x_ram #(.WIDTH(a64x_pkg::XLEN), .DEPTH(a64x_pkg::NUM_REGS)) u_ram_b (
      .clock   (clock),
      .wr_en   (commit_wr),
      .wr_addr (c_wr_idx),
      .wr_data (c_wr_val),
      .rd_en   (req_accept),
      .rd_addr (rd_addr_b),
      .rd_data (ram_b_data)
   );

   // never-written entries read as zero; bypass covers the write on the read edge
   always_comb begin
      if (fwd_valid_ff && fwd_idx_ff == opa_idx_ff) begin
         opa = fwd_val_ff;
      end else if (valid_ff[opa_idx_ff]) begin
         opa = ram_a_data;
      end else begin
         opa = '0;
      end
      if (fwd_valid_ff && fwd_idx_ff == opb_idx_ff) begin
         opb = fwd_val_ff;
      end else if (valid_ff[opb_idx_ff]) begin
         opb = ram_b_data;
      end else begin
         opb = '0;
      end
   end

   a64x_exec u_exec (
      .instr_word (s1_word_ff),
      .instr_addr (s1_addr_ff),
      .opa_value  (opa),
      .opb_value  (opb),
      .result     (ex_res)
   );

   always_comb begin
      c_wr_en    = 1'b0;
      c_wr_idx   = '0;
      c_wr_val   = '0;
      c_next_pc  = '0;
      c_flag_wr  = 1'b0;
      c_flags    = nzcv_ff;
      c_read_val = '0;
      c_unimp    = 1'b0;
      case (s1_op_ff)
         a64x_pkg::OP_EXEC: begin
            c_wr_en   = ex_res.wr_en;
            c_wr_idx  = ex_res.wr_idx;
            c_wr_val  = ex_res.wr_val;
            c_next_pc = ex_res.next_pc;
            c_flag_wr = ex_res.flag_wr;
            c_flags   = ex_res.flag_wr ? ex_res.flags : nzcv_ff;
            c_unimp   = ex_res.unimp;
         end
         a64x_pkg::OP_WRITE: begin
            c_wr_en  = 1'b1;
            c_wr_idx = s1_idx_ff;
            c_wr_val = s1_value_ff;
         end
         a64x_pkg::OP_READ: begin
            c_read_val = opa;
         end
         default: begin
            c_wr_en = 1'b0;
         end
      endcase
   end

   assign commit_wr    = s1_move && c_wr_en;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         valid_ff     <= '0;
         nzcv_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            fwd_valid_ff <= commit_wr;
         end
         if (commit_wr) begin
            valid_ff[c_wr_idx] <= 1'b1;
         end
         if (s1_move && c_flag_wr) begin
            nzcv_ff <= c_flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff    <= req_op;
         s1_word_ff  <= req_instr_word;
         s1_addr_ff  <= req_instr_addr;
         s1_idx_ff   <= req_reg_index;
         s1_value_ff <= req_reg_value;
         opa_idx_ff  <= rd_addr_a;
         opb_idx_ff  <= rd_addr_b;
         fwd_idx_ff  <= c_wr_idx;
         fwd_val_ff  <= c_wr_val;
      end
      if (s1_move) begin
         rsp_next_pc_ff      <= c_next_pc;
         rsp_dest_written_ff <= c_wr_en;
         rsp_dest_index_ff   <= c_wr_idx;
         rsp_dest_value_ff   <= c_wr_val;
         rsp_flags_ff        <= c_flags;
         rsp_read_value_ff   <= c_read_val;
         rsp_unimp_ff        <= c_unimp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pc       = rsp_next_pc_ff;
   assign rsp_dest_written  = rsp_dest_written_ff;
   assign rsp_dest_index    = rsp_dest_index_ff;
   assign rsp_dest_value    = rsp_dest_value_ff;
   assign rsp_flags_nzcv    = rsp_flags_ff;
   assign rsp_read_value    = rsp_read_value_ff;
   assign rsp_unimplemented = rsp_unimp_ff;

endmodule

[sv/a64x_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the integer subset execute block, with its bind.
module a64x_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [a64x_pkg::XLEN-1:0]           rsp_next_pc,
   input  logic [a64x_pkg::XLEN-1:0]           rsp_dest_value,
   input  logic [a64x_pkg::FLAGS_W-1:0]        rsp_flags_nzcv,
   input  logic                                rsp_unimplemented
);

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       seen_ff;
   logic [a64x_pkg::FLAGS_W-1:0] last_flags_ff;

   assign req_acc    = req_valid && !req_stall;
   assign rsp_acc    = rsp_valid && !rsp_stall;
   assign pending_in = pending_ff + {1'b0, req_acc} - {1'b0, rsp_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         seen_ff    <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_acc) begin
            seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_acc) begin
         last_flags_ff <= rsp_flags_nzcv;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dest_value) && $stable(rsp_next_pc))
      else $error("stalled result transaction changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result transaction without an accepted request");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc && !rsp_valid |=> ##1 rsp_valid)
      else $error("result transaction late");

   a_unimp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_unimplemented && seen_ff |-> rsp_flags_nzcv == last_flags_ff)
      else $error("unimplemented instruction changed the flags");

endmodule

bind arm64_integer_subset_execute a64x_checker u_a64x_checker (.*);

[tb/exec_retire_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the integer subset execute block: watches both channels, predicts and compares.
module exec_retire_checker import a64x_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [31:0]          req_instr_word,
   input  logic [XLEN-1:0]      req_instr_addr,
   input  logic [REG_IDX_W-1:0] req_reg_index,
   input  logic [XLEN-1:0]      req_reg_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [XLEN-1:0]      rsp_next_pc,
   input  logic                 rsp_dest_written,
   input  logic [REG_IDX_W-1:0] rsp_dest_index,
   input  logic [XLEN-1:0]      rsp_dest_value,
   input  logic [FLAGS_W-1:0]   rsp_flags_nzcv,
   input  logic [XLEN-1:0]      rsp_read_value,
   input  logic                 rsp_unimplemented,
   output int                   mismatch_count,
   output int                   in_flight
);

   typedef struct packed {
      logic [XLEN-1:0]      next_pc;
      logic                 written;
      logic [REG_IDX_W-1:0] index;
      logic [XLEN-1:0]      value;
      logic [FLAGS_W-1:0]   nzcv;
      logic [XLEN-1:0]      readback;
      logic                 unimp;
   } retire_type;

   localparam logic [XLEN-1:0] LOW_WORD = 64'h0000_0000_FFFF_FFFF;

   logic [XLEN-1:0]    gpr [NUM_REGS];
   logic [FLAGS_W-1:0] nzcv_q;
   retire_type         res;
   retire_type         retire_q [$];
   retire_type         got;
   retire_type         want;

   function automatic logic [XLEN-1:0] src(input logic [4:0] n, input logic sp);
      return (n == ZERO_REG && !sp) ? '0 : gpr[n];
   endfunction

   function automatic void dst(input logic [4:0] n, input logic [XLEN-1:0] v, input logic sp);
      if (n == ZERO_REG && !sp)
         return;
      gpr[n]    = v;
      res.written = 1'b1;
      res.index = n;
      res.value = v;
   endfunction

   function automatic logic [XLEN-1:0] addsub(input logic [XLEN-1:0] x, input logic [XLEN-1:0] y,
                                              input logic sub, input logic is64, input logic setf);
      logic [XLEN-1:0] mask;
      logic [XLEN-1:0] r;
      logic [XLEN:0]   sum;
      logic            n, c, v;
      mask = is64 ? '1 : LOW_WORD;
      x &= mask;
      y &= mask;
      if (sub)
         y = ~y & mask;
      sum = {1'b0, x} + {1'b0, y} + 65'(sub);
      if (is64) begin
         r = sum[63:0];
         c = sum[64];
         v = ~(x[63] ^ y[63]) & (x[63] ^ r[63]);
         n = r[63];
      end else begin
         r = {32'b0, sum[31:0]};
         c = sum[32];
         v = ~(x[31] ^ y[31]) & (x[31] ^ r[31]);
         n = r[31];
      end
      if (setf)
         nzcv_q = {n, r == '0, c, v};
      return r;
   endfunction

   function automatic logic [XLEN-1:0] shifted(input logic [XLEN-1:0] v, input logic [1:0] ty,
                                               input logic [5:0] amt, input logic is64);
      logic [XLEN-1:0] mask;
      mask = is64 ? '1 : LOW_WORD;
      v &= mask;
      case (ty)
         SH_LSL: return (v << amt) & mask;
         SH_LSR: return v >> amt;
         default: begin
            if (!is64)
               v = {{32{v[31]}}, v[31:0]};
            v = $signed(v) >>> amt;
            return v & mask;
         end
      endcase
   endfunction

   function automatic logic [XLEN-1:0] extended(input logic [XLEN-1:0] v, input logic [2:0] opt,
                                                input logic [2:0] amt, input logic is64);
      logic [XLEN-1:0] mask;
      mask = is64 ? '1 : LOW_WORD;
      case (opt)
         EXT_UXTB: v = {56'b0, v[7:0]};
         EXT_UXTH: v = {48'b0, v[15:0]};
         EXT_UXTW: v = {32'b0, v[31:0]};
         EXT_SXTB: v = {{56{v[7]}}, v[7:0]};
         EXT_SXTH: v = {{48{v[15]}}, v[15:0]};
         EXT_SXTW: v = {{32{v[31]}}, v[31:0]};
         default: ;
      endcase
      return (v << amt) & mask;
   endfunction

   function automatic void run_word(input logic [31:0] w, input logic [XLEN-1:0] addr);
      logic            sf, s;
      logic [4:0]      rd, rn, rm;
      logic [1:0]      opc, hw;
      logic [XLEN-1:0] imm, val, y;
      sf = w[31];
      s  = w[29];
      rd = w[4:0];
      rn = w[9:5];
      rm = w[20:16];
      res.next_pc = addr + 64'd4;
      if (w == NOP_WORD) begin
      end else if ((w & RET_MASK) == RET_MATCH) begin
         res.next_pc = src(rn, 1'b0);
      end else if (w[28:23] == CLASS_MOVW) begin
         opc = w[30:29];
         hw  = w[22:21];
         imm = {48'b0, w[20:5]} << {hw, 4'b0};
         if (opc == MOV_RSVD || (!sf && hw[1])) begin
            res.unimp = 1'b1;
         end else begin
            case (opc)
               MOV_N: val = ~imm;
               MOV_Z: val = imm;
               default: val = (src(rd, 1'b0) & ~(64'hFFFF << {hw, 4'b0})) | imm;
            endcase
            if (!sf)
               val[63:32] = '0;
            dst(rd, val, 1'b0);
         end
      end else if (w[28:23] == CLASS_ADDI) begin
         imm = {52'b0, w[21:10]};
         if (w[22])
            imm = imm << 12;
         val = addsub(src(rn, 1'b1), imm, w[30], sf, s);
         dst(rd, val, !s);
      end else if (w[28:24] == CLASS_ADDR && !w[30]) begin
         if (!w[21]) begin
            if (w[23:22] == SH_RSVD || (!sf && w[15])) begin
               res.unimp = 1'b1;
            end else begin
               y   = shifted(src(rm, 1'b0), w[23:22], w[15:10], sf);
               val = addsub(src(rn, 1'b0), y, 1'b0, sf, s);
               dst(rd, val, 1'b0);
            end
         end else begin
            if (w[23:22] != 2'b00 || w[12:10] > EXT_MAX_SHIFT) begin
               res.unimp = 1'b1;
            end else begin
               y   = extended(src(rm, 1'b0), w[15:13], w[12:10], sf);
               val = addsub(src(rn, 1'b1), y, 1'b0, sf, s);
               dst(rd, val, !s);
            end
         end
      end else begin
         res.unimp = 1'b1;
      end
   endfunction

   function automatic retire_type retire_transaction(input op_type op, input logic [31:0] w,
                                                     input logic [XLEN-1:0] addr,
                                                     input logic [4:0] ri,
                                                     input logic [XLEN-1:0] rv);
      res = '0;
      case (op)
         OP_EXEC:  run_word(w, addr);
         OP_WRITE: dst(ri, rv, 1'b1);
         OP_READ:  res.readback = gpr[ri];
         default: ;
      endcase
      res.nzcv = nzcv_q;
      return res;
   endfunction

   function automatic void note_failure(input string what, input retire_type e,
                                        input retire_type a);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: exp/got pc %h/%h wr %b/%b idx %0d/%0d val %h/%h", $realtime, what,
                  e.next_pc, a.next_pc, e.written, a.written, e.index, a.index,
                  e.value, a.value, "\n   nzcv %h/%h read %h/%h unimp %b/%b",
                  e.nzcv, a.nzcv, e.readback, a.readback, e.unimp, a.unimp);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++)
            gpr[i] = '0;
         nzcv_q = '0;
         retire_q.delete();
         in_flight = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_next_pc, rsp_dest_written, rsp_dest_index, rsp_dest_value,
                   rsp_flags_nzcv, rsp_read_value, rsp_unimplemented};
            if (retire_q.size() == 0) begin
               note_failure("transaction with none pending", '0, got);
            end else begin
               want = retire_q.pop_front();
               if (got !== want)
                  note_failure("mismatch", want, got);
            end
         end
         if (req_valid && !req_stall)
            retire_q.push_back(retire_transaction(op_type'(req_opcode), req_instr_word,
                                                  req_instr_addr, req_reg_index,
                                                  req_reg_value));
         in_flight = retire_q.size();
      end
   end

endmodule

[tb/arm64_integer_subset_execute_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the integer subset execute block: clock, reset, stimulus, stalls and verdict.
module arm64_integer_subset_execute_tb;
   import a64x_pkg::*;

   localparam int          QUIET_LIMIT = 400;
   localparam int          RANDOM_ITEMS = 700;
   localparam logic [31:0] HINT_YIELD = 32'hD503_203F;
   localparam logic [31:0] SUB_FORM   = 32'h4000_0000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_opcode;
   logic [31:0]          req_instr_word;
   logic [XLEN-1:0]      req_instr_addr;
   logic [REG_IDX_W-1:0] req_reg_index;
   logic [XLEN-1:0]      req_reg_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [XLEN-1:0]      rsp_next_pc;
   logic                 rsp_dest_written;
   logic [REG_IDX_W-1:0] rsp_dest_index;
   logic [XLEN-1:0]      rsp_dest_value;
   logic [FLAGS_W-1:0]   rsp_flags_nzcv;
   logic [XLEN-1:0]      rsp_read_value;
   logic                 rsp_unimplemented;
   int                   mismatch_count;
   int                   in_flight;
   int                   quiet;
   bit                   steady;
   logic [XLEN-1:0]      pc;

   arm64_integer_subset_execute u_top (.*);

   exec_retire_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet == QUIET_LIMIT) begin
            $display("[arm64_integer_subset_execute] ERROR");
            $finish;
         end
      end
   end

   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic logic [31:0] enc_movw(logic sf, logic [1:0] opc, logic [1:0] hw,
                                            logic [15:0] imm, logic [4:0] rd);
      return {sf, opc, CLASS_MOVW, hw, imm, rd};
   endfunction

   function automatic logic [31:0] enc_addi(logic sf, logic sub, logic setf, logic sh,
                                            logic [11:0] imm, logic [4:0] rn, logic [4:0] rd);
      return {sf, sub, setf, CLASS_ADDI, sh, imm, rn, rd};
   endfunction

   function automatic logic [31:0] enc_adds(logic sf, logic setf, logic [1:0] ty, logic [4:0] rm,
                                            logic [5:0] amt, logic [4:0] rn, logic [4:0] rd);
      return {sf, 1'b0, setf, CLASS_ADDR, ty, 1'b0, rm, amt, rn, rd};
   endfunction

   function automatic logic [31:0] enc_adde(logic sf, logic setf, logic [2:0] opt,
                                            logic [2:0] amt, logic [4:0] rm, logic [4:0] rn,
                                            logic [4:0] rd);
      return {sf, 1'b0, setf, CLASS_ADDR, 2'b00, 1'b1, rm, opt, amt, rn, rd};
   endfunction

   function automatic logic [31:0] enc_ret(logic [4:0] rn);
      return RET_MATCH | {22'b0, rn, 5'b0};
   endfunction

   function automatic logic [4:0] pick_reg();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55)
         return 5'($urandom_range(0, 3));
      if (k < 70)
         return ZERO_REG;
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [XLEN-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7FFF_FFFF_FFFF_FFFF;
         4: return {32'h0, $urandom};
         5: return 64'h0000_0000_FFFF_FFFF;
         6: return 64'($urandom_range(0, 15));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [XLEN-1:0] pick_addr();
      if ($urandom_range(0, 9) == 0)
         return '1 - 64'($urandom_range(0, 15));
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] random_word();
      int          k;
      logic        sf;
      logic [1:0]  opc, hw, ty;
      logic [5:0]  amt;
      logic [2:0]  eamt;
      logic [31:0] w;
      k  = $urandom_range(0, 99);
      sf = 1'($urandom_range(0, 1));
      if (k < 25) begin
         case ($urandom_range(0, 19))
            0:              opc = MOV_RSVD;
            1, 2, 3, 4, 5, 6: opc = MOV_N;
            7, 8, 9, 10, 11, 12: opc = MOV_Z;
            default:        opc = MOV_K;
         endcase
         if (sf || $urandom_range(0, 9) == 0)
            hw = 2'($urandom_range(0, 3));
         else
            hw = 2'($urandom_range(0, 1));
         w = enc_movw(sf, opc, hw, 16'($urandom), pick_reg());
      end else if (k < 50) begin
         w = enc_addi(sf, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 12'($urandom), pick_reg(), pick_reg());
      end else if (k < 65) begin
         ty = ($urandom_range(0, 19) == 0) ? SH_RSVD : 2'($urandom_range(0, 2));
         if (sf || $urandom_range(0, 19) == 0)
            amt = 6'($urandom_range(0, 63));
         else
            amt = 6'($urandom_range(0, 31));
         w = enc_adds(sf, 1'($urandom_range(0, 1)), ty, pick_reg(), amt, pick_reg(),
                      pick_reg());
         if ($urandom_range(0, 19) == 0)
            w |= SUB_FORM;
      end else if (k < 80) begin
         eamt = ($urandom_range(0, 14) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         w = enc_adde(sf, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), eamt, pick_reg(),
                      pick_reg(), pick_reg());
         if ($urandom_range(0, 19) == 0)
            w |= 32'($urandom_range(1, 3)) << 22;
      end else if (k < 86) begin
         w = enc_ret(pick_reg());
         if ($urandom_range(0, 9) == 0)
            w |= 32'($urandom_range(1, 31));
      end else if (k < 90) begin
         w = NOP_WORD;
      end else if (k < 93) begin
         w = NOP_WORD | (32'($urandom_range(1, 127)) << 5);
      end else begin
         w = $urandom;
      end
      return w;
   endfunction

   task automatic issue(input op_type op, input logic [31:0] w, input logic [XLEN-1:0] addr,
                        input logic [4:0] ri, input logic [XLEN-1:0] rv);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode     = op;
      req_instr_word = w;
      req_instr_addr = addr;
      req_reg_index  = ri;
      req_reg_value  = rv;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic exec_at(input logic [31:0] w);
      issue(OP_EXEC, w, pc, 5'($urandom), {$urandom, $urandom});
      pc += 64'd4;
   endtask

   task automatic random_transaction();
      int k;
      k = $urandom_range(0, 99);
      if (k < 11)
         issue(OP_WRITE, $urandom, pick_addr(), pick_reg(), pick_value());
      else if (k < 19)
         issue(OP_READ, $urandom, pick_addr(), 5'($urandom), {$urandom, $urandom});
      else if (k < 21)
         issue(OP_IDLE, $urandom, pick_addr(), 5'($urandom), {$urandom, $urandom});
      else
         issue(OP_EXEC, random_word(), pick_addr(), 5'($urandom), {$urandom, $urandom});
   endtask

   // result side: fresh stall length per transaction
   initial begin
      int n;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         n = draw_wait();
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_IDLE;
      req_instr_word = '0;
      req_instr_addr = '0;
      req_reg_index  = '0;
      req_reg_value  = '0;
      steady         = 1'b0;
      pc             = 64'h0000_0000_0040_0000;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      issue(OP_WRITE, '0, '0, 5'd1, '1);
      issue(OP_WRITE, '0, '0, 5'd2, 64'h8000_0000_0000_0000);
      issue(OP_WRITE, '0, '0, ZERO_REG, 64'h0000_0000_0000_1000);
      issue(OP_READ, '0, '0, ZERO_REG, '0);
      exec_at(enc_movw(1'b1, MOV_Z, 2'd3, 16'hFFFF, 5'd3));
      exec_at(enc_movw(1'b0, MOV_N, 2'd0, 16'h0000, 5'd4));
      exec_at(enc_movw(1'b1, MOV_K, 2'd1, 16'h1234, 5'd3));
      exec_at(enc_movw(1'b1, MOV_RSVD, 2'd0, 16'hABCD, 5'd5));
      exec_at(enc_movw(1'b0, MOV_Z, 2'd2, 16'h5555, 5'd5));
      exec_at(enc_movw(1'b1, MOV_Z, 2'd0, 16'h7777, ZERO_REG));
      // carry out to zero, then signed overflow, then a 32-bit subtract from the stack pointer
      exec_at(enc_addi(1'b1, 1'b0, 1'b1, 1'b0, 12'd1, 5'd1, 5'd0));
      exec_at(enc_addi(1'b1, 1'b1, 1'b1, 1'b0, 12'd1, 5'd2, 5'd0));
      exec_at(enc_addi(1'b0, 1'b1, 1'b1, 1'b0, 12'd1, ZERO_REG, 5'd0));
      exec_at(enc_addi(1'b1, 1'b0, 1'b0, 1'b1, 12'hFFF, ZERO_REG, ZERO_REG));
      exec_at(enc_addi(1'b1, 1'b0, 1'b1, 1'b0, 12'd5, 5'd1, ZERO_REG));
      exec_at(enc_adds(1'b1, 1'b1, SH_ASR, 5'd2, 6'd63, 5'd1, 5'd5));
      exec_at(enc_adds(1'b0, 1'b0, SH_LSL, 5'd2, 6'd32, 5'd1, 5'd5));
      exec_at(enc_adds(1'b1, 1'b0, SH_RSVD, 5'd2, 6'd1, 5'd1, 5'd5));
      exec_at(enc_adde(1'b1, 1'b1, EXT_SXTW, 3'd4, 5'd1, ZERO_REG, 5'd6));
      exec_at(enc_adde(1'b1, 1'b0, EXT_UXTB, 3'd5, 5'd1, 5'd2, 5'd6));
      exec_at(enc_adde(1'b1, 1'b0, EXT_UXTH, 3'd1, 5'd1, 5'd2, 5'd6) | (32'd1 << 22));
      exec_at(enc_adds(1'b1, 1'b0, SH_LSL, 5'd1, 6'd0, 5'd2, 5'd7) | SUB_FORM);
      exec_at(enc_ret(5'd1));
      exec_at(enc_ret(ZERO_REG));
      pc = 64'hFFFF_FFFF_FFFF_FFFC;
      exec_at(NOP_WORD);
      exec_at(HINT_YIELD);
      issue(OP_IDLE, '1, '1, 5'd31, '1);

      req_valid = 1'b0;
      wait (in_flight == 0);
      @(negedge clock);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0)
            steady = ($urandom_range(0, 3) == 0);
         if (i % 150 == 149) begin
            req_valid = 1'b0;
            wait (in_flight == 0);
            @(negedge clock);
         end
         random_transaction();
      end

      req_valid = 1'b0;
      wait (in_flight == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && in_flight == 0)
         $display("[arm64_integer_subset_execute] OK");
      else
         $display("[arm64_integer_subset_execute] ERROR");
      $finish;
   end

endmodule

[files.f]
sv/a64x_pkg.sv
sv/a64x_ram.sv
sv/a64x_exec.sv
sv/arm64_integer_subset_execute.sv
sv/a64x_checker.sv
tb/exec_retire_checker.sv
tb/arm64_integer_subset_execute_tb.sv
